>>> sv/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared constants, codes and types of the multi counter FIFO bank.
// ----------------------------------------------------------------------------
package mcfb_pkg;

	localparam int NUM_COUNTERS = 8;
	localparam int QUEUE_DEPTH  = 16;
	localparam int ID_WIDTH     = 16;

	localparam int OP_W     = 1;
	localparam int CTR_W    = 3;
	localparam int PID_W    = 16;
	localparam int STATUS_W = 3;
	localparam int WAIT_W   = 5;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	localparam int CIDX_W      = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_COUNTERS * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_ENTER = 1'b0;
	localparam logic [OP_W-1:0] OP_SERVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_COUNTER = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SERVED      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

	typedef struct packed {
		logic                    is_serve;
		logic                    bad;
		logic [CIDX_W-1:0]       ctr;
		logic [ID_WIDTH-1:0]     pid;
		logic [NUM_COUNTERS-1:0] active;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CIDX_W-1:0]   ctr;
		logic                use_ram;
		logic [OCC_W-1:0]    waiting;
		logic                last;
	} result_t;

	typedef enum logic {
		BK_IDLE,
		BK_SERVE
	} back_state_t;

endpackage

>>> sv/mcfb_ram.sv
// ----------------------------------------------------------------------------
// mcfb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mcfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/mcfb_front.sv
// ----------------------------------------------------------------------------
// mcfb_front
// Input side: holds the active counter register and classifies each item.
// ----------------------------------------------------------------------------
module mcfb_front import mcfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [CTR_W-1:0]  counter_index,
	input  logic [PID_W-1:0]  passenger_id,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_cmd
);

	logic [CFG_W-1:0] counters_in_use_q;
	logic [CFG_W-1:0] active_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counters_in_use_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			counters_in_use_q <= cfg_wr_data;
		end
	end

	assign active_cnt = (counters_in_use_q > CFG_W'(NUM_COUNTERS)) ?
		CFG_W'(NUM_COUNTERS) : counters_in_use_q;

	always_comb begin
		q_cmd.is_serve = (op == OP_SERVE);
		q_cmd.bad      = (CFG_W'(counter_index) >= active_cnt);
		q_cmd.ctr      = CIDX_W'(counter_index);
		q_cmd.pid      = ID_WIDTH'(passenger_id);
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			q_cmd.active[i] = (CFG_W'(i) < active_cnt);
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

>>> sv/mcfb_cmdq.sv
// ----------------------------------------------------------------------------
// mcfb_cmdq
// Short command queue between the classifying front and the execution back.
// ----------------------------------------------------------------------------
module mcfb_cmdq import mcfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_cmd
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/mcfb_back.sv
// ----------------------------------------------------------------------------
// mcfb_back
// Execution side: queue pointers, identifier store, serve walk, result output.
// ----------------------------------------------------------------------------
module mcfb_back import mcfb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cmd_t                q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [CTR_W-1:0]    served_counter,
	output logic [PID_W-1:0]    served_id,
	output logic [WAIT_W-1:0]   waiting_count,
	output logic                last_result
);

	logic [PTR_W-1:0]        head_q [NUM_COUNTERS];
	logic [PTR_W-1:0]        tail_q [NUM_COUNTERS];
	logic [OCC_W-1:0]        occ_q  [NUM_COUNTERS];
	back_state_t             state_q, state_d;
	logic [NUM_COUNTERS-1:0] mask_q, mask_d;
	logic [NUM_COUNTERS-1:0] nonempty;
	logic [NUM_COUNTERS-1:0] sel_onehot;
	logic [CIDX_W-1:0]       sel;

	result_t                 res_s1;
	logic                    res_valid_s1;
	result_t                 out_res_q;
	logic [ID_WIDTH-1:0]     out_id_q;
	logic                    out_valid_q;

	logic                    out_free;
	logic                    slot_free;
	logic                    s1_load;
	result_t                 s1_d;
	logic                    do_enq;
	logic                    do_deq;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [ID_WIDTH-1:0]     ram_rdata;

	assign out_free  = !out_valid_q || out_ready;
	assign slot_free = !res_valid_s1 || out_free;

	always_comb begin
		sel = '0;
		for (int i = NUM_COUNTERS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = CIDX_W'(i);
			end
		end
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			nonempty[i]   = (occ_q[i] != '0);
			sel_onehot[i] = (CIDX_W'(i) == sel);
		end
	end

	always_comb begin
		state_d = state_q;
		mask_d  = mask_q;
		q_pop   = 1'b0;
		s1_load = 1'b0;
		s1_d    = '0;
		do_enq  = 1'b0;
		do_deq  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop   = 1'b1;
					s1_load = 1'b1;
					s1_d.last = 1'b1;
					if (q_cmd.is_serve) begin
						mask_d = q_cmd.active & nonempty;
						if (mask_d == '0) begin
							s1_d.status = ST_EMPTY;
						end else begin
							s1_load = 1'b0;
							state_d = BK_SERVE;
						end
					end else if (q_cmd.bad) begin
						s1_d.status = ST_BAD_COUNTER;
					end else if (occ_q[q_cmd.ctr] == OCC_W'(QUEUE_DEPTH)) begin
						s1_d.status = ST_FULL;
					end else begin
						s1_d.status = ST_ENQUEUED;
						do_enq      = 1'b1;
					end
				end
			end
			BK_SERVE: begin
				if (slot_free) begin
					do_deq       = 1'b1;
					s1_load      = 1'b1;
					mask_d       = mask_q & ~sel_onehot;
					s1_d.status  = ST_SERVED;
					s1_d.ctr     = sel;
					s1_d.use_ram = 1'b1;
					s1_d.waiting = occ_q[sel] - 1'b1;
					s1_d.last    = (mask_d == '0);
					if (mask_d == '0) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign ram_we    = do_enq;
	assign ram_waddr = ADDR_W'(q_cmd.ctr) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[q_cmd.ctr]);
	assign ram_re    = do_deq;
	assign ram_raddr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[sel]);

	mcfb_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_cmd.pid),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			mask_q  <= '0;
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			mask_q  <= mask_d;
			if (do_enq) begin
				tail_q[q_cmd.ctr] <= (tail_q[q_cmd.ctr] == PTR_W'(QUEUE_DEPTH - 1)) ?
					'0 : tail_q[q_cmd.ctr] + 1'b1;
				occ_q[q_cmd.ctr]  <= occ_q[q_cmd.ctr] + 1'b1;
			end
			if (do_deq) begin
				head_q[sel] <= (head_q[sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[sel] + 1'b1;
				occ_q[sel]  <= occ_q[sel] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_load) begin
				res_valid_s1 <= 1'b1;
			end else if (out_free) begin
				res_valid_s1 <= 1'b0;
			end
			if (res_valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			res_s1 <= s1_d;
		end
		if (res_valid_s1 && out_free) begin
			out_res_q <= res_s1;
			out_id_q  <= res_s1.use_ram ? ram_rdata : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign served_counter = CTR_W'(out_res_q.ctr);
	assign served_id      = PID_W'(out_id_q);
	assign waiting_count  = WAIT_W'(out_res_q.waiting);
	assign last_result    = out_res_q.last;

endmodule

>>> sv/multi_counter_fifo_bank.sv
// ----------------------------------------------------------------------------
// multi_counter_fifo_bank
// Bank of per-counter FIFO queues of passenger IDs with round service.
// ----------------------------------------------------------------------------
// An enter item passes through the execution side and gives one result.
// A serve item first snapshots the non-empty active queues, then serves
// each snapshotted queue in turn, each pop reading the shared identifier RAM
// through its single read port; so a serve gives n results for n queues
// (at most NUM_COUNTERS), or one result when nothing waits. Results leave at
// most one per cycle through an output register. A two-entry command queue
// lets inputs be taken while the execution side is busy. The identifier
// store needs no clearing after reset; queues start empty at once.
module multi_counter_fifo_bank import mcfb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [CTR_W-1:0]    counter_index,
	input  logic [PID_W-1:0]    passenger_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [CTR_W-1:0]    served_counter,
	output logic [PID_W-1:0]    served_id,
	output logic [WAIT_W-1:0]   waiting_count,
	output logic                last_result
);

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;

	mcfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.counter_index (counter_index),
		.passenger_id  (passenger_id),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	mcfb_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_cmd   (pop_cmd)
	);

	mcfb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_not_empty),
		.q_cmd          (pop_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.served_counter (served_counter),
		.served_id      (served_id),
		.waiting_count  (waiting_count),
		.last_result    (last_result)
	);

endmodule

>>> sv/mcfb_checker.sv
// ----------------------------------------------------------------------------
// mcfb_checker
// Port-level checks of the multi counter FIFO bank, bound to the top level.
// ----------------------------------------------------------------------------
module mcfb_checker import mcfb_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [CTR_W-1:0]    served_counter,
	input logic [PID_W-1:0]    served_id,
	input logic [WAIT_W-1:0]   waiting_count,
	input logic                last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(served_id) &&
		$stable(served_counter) && $stable(waiting_count) && $stable(last_result))
		else $error("result changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SERVED |-> last_result)
		else $error("non-serve result not marked last");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SERVED |->
		served_id == '0 && served_counter == '0 && waiting_count == '0)
		else $error("non-serve result carries data");

	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SERVED |-> waiting_count < WAIT_W'(QUEUE_DEPTH))
		else $error("waiting count after pop exceeds depth");

endmodule

bind multi_counter_fifo_bank mcfb_checker u_mcfb_checker (.*);
